### hdl/shs_pkg.sv
// Shared types, constants and SHA-256 round functions for the stream hasher.
package shs_pkg;

    localparam int unsigned CountW    = 61;
    localparam int unsigned BlkWords  = 16;
    localparam int unsigned HashWords = 8;

    localparam logic [5:0] LastRound = 6'd63;
    localparam logic [5:0] LastPos   = 6'd63;
    localparam logic [5:0] LenPos    = 6'd56;
    localparam logic [2:0] LastIdx   = 3'd7;
    localparam logic [7:0] PadByte   = 8'h80;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] msg_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_ROUND,
        CP_ADD
    } t_core_phase;

    // Commands from the sequencer to the compression core
    typedef struct packed {
        logic        start;
        logic        init;
        logic        wr_byte;
        logic        wr_pad;
        logic        wr_len;
        logic        clr;
        logic [3:0]  idx;
        logic [1:0]  lane;
        logic [7:0]  data;
        logic [63:0] bit_len;
    } t_core_cmd;

    function automatic t_word byte_lane(input logic [7:0] b, input logic [1:0] k);
        t_word r;
        case (k)
            2'd0:    r = {b, 24'h000000};
            2'd1:    r = {8'h00, b, 16'h0000};
            2'd2:    r = {16'h0000, b, 8'h00};
            default: r = {24'h000000, b};
        endcase
        return r;
    endfunction

    // Bytes of the word already filled ahead of lane k
    function automatic t_word keep_mask(input logic [1:0] k);
        t_word r;
        case (k)
            2'd0:    r = 32'h0000_0000;
            2'd1:    r = 32'hFF00_0000;
            2'd2:    r = 32'hFFFF_0000;
            default: r = 32'hFFFF_FF00;
        endcase
        return r;
    endfunction

    function automatic t_word ssig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic t_word bsig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word bsig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        t_word r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic t_word round_k(input logic [5:0] t);
        t_word r;
        case (t)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

### hdl/shs_core.sv
// SHA-256 compression core: block buffer / schedule window, round unit and chain value.
module shs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shs_pkg::t_core_cmd i_cmd,
    input  logic [2:0]         i_word_sel,
    output logic               o_done,
    output shs_pkg::t_word     o_digest_word
);

    shs_pkg::t_word      r_win   [shs_pkg::BlkWords];
    shs_pkg::t_word      n_win   [shs_pkg::BlkWords];
    shs_pkg::t_word      r_wv    [shs_pkg::HashWords];
    shs_pkg::t_word      r_chain [shs_pkg::HashWords];
    logic [5:0]          r_round;
    shs_pkg::t_core_phase r_phase;
    shs_pkg::t_core_phase n_phase;

    logic           round_en;
    logic           load_en;
    shs_pkg::t_word w_t;
    shs_pkg::t_word w_new;
    shs_pkg::t_word t1;
    shs_pkg::t_word t2;
    shs_pkg::t_word ch;
    shs_pkg::t_word maj;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            shs_pkg::CP_IDLE: begin
                if (i_cmd.start) n_phase = shs_pkg::CP_ROUND;
            end
            shs_pkg::CP_ROUND: begin
                if (r_round == shs_pkg::LastRound) n_phase = shs_pkg::CP_ADD;
            end
            shs_pkg::CP_ADD: begin
                n_phase = shs_pkg::CP_IDLE;
            end
            default: begin
                n_phase = shs_pkg::CP_IDLE;
            end
        endcase
    end

    // phase outputs
    always_comb begin
        o_done   = 1'b0;
        round_en = 1'b0;
        load_en  = 1'b0;
        case (r_phase)
            shs_pkg::CP_IDLE:  load_en  = i_cmd.start;
            shs_pkg::CP_ROUND: round_en = 1'b1;
            shs_pkg::CP_ADD:   o_done   = 1'b1;
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    // one round: W[t] leaves the window head, W[t+16] enters at the tail
    always_comb begin
        w_t   = r_win[0];
        w_new = shs_pkg::ssig1(r_win[14]) + r_win[9] + shs_pkg::ssig0(r_win[1]) + r_win[0];
        ch    = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
        maj   = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
        t1    = r_wv[7] + shs_pkg::bsig1(r_wv[4]) + ch + shs_pkg::round_k(r_round) + w_t;
        t2    = shs_pkg::bsig0(r_wv[0]) + maj;
    end

    always_comb begin
        for (int i = 0; i < shs_pkg::BlkWords; i++) begin
            n_win[i] = r_win[i];
            if (round_en) begin
                if (i == shs_pkg::BlkWords - 1) n_win[i] = w_new;
                else                            n_win[i] = r_win[(i + 1) % shs_pkg::BlkWords];
            end else begin
                if (i_cmd.clr) n_win[i] = '0;
                if (i_cmd.wr_byte && (i_cmd.idx == 4'(i))) begin
                    if (i_cmd.lane == 2'd0)
                        n_win[i] = shs_pkg::byte_lane(i_cmd.data, i_cmd.lane);
                    else
                        n_win[i] = r_win[i] | shs_pkg::byte_lane(i_cmd.data, i_cmd.lane);
                end
                if (i_cmd.wr_pad) begin
                    if (i_cmd.idx == 4'(i))
                        n_win[i] = (r_win[i] & shs_pkg::keep_mask(i_cmd.lane))
                                 | shs_pkg::byte_lane(shs_pkg::PadByte, i_cmd.lane);
                    else if (4'(i) > i_cmd.idx)
                        n_win[i] = '0;
                end
                if (i_cmd.wr_len && (i == shs_pkg::BlkWords - 2)) n_win[i] = i_cmd.bit_len[63:32];
                if (i_cmd.wr_len && (i == shs_pkg::BlkWords - 1)) n_win[i] = i_cmd.bit_len[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (load_en) begin
            r_wv <= r_chain;
        end else if (round_en) begin
            r_wv[0] <= t1 + t2;
            r_wv[1] <= r_wv[0];
            r_wv[2] <= r_wv[1];
            r_wv[3] <= r_wv[2];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[5] <= r_wv[4];
            r_wv[6] <= r_wv[5];
            r_wv[7] <= r_wv[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= shs_pkg::CP_IDLE;
            r_round <= '0;
        end else begin
            r_phase <= n_phase;
            if (load_en)       r_round <= '0;
            else if (round_en) r_round <= r_round + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < shs_pkg::HashWords; i++) r_chain[i] <= shs_pkg::init_hash(3'(i));
        end else if (r_phase == shs_pkg::CP_ADD) begin
            for (int i = 0; i < shs_pkg::HashWords; i++) r_chain[i] <= r_chain[i] + r_wv[i];
        end
    end

    assign o_digest_word = r_chain[i_word_sel];

endmodule

### hdl/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer and digest output.
// Takes one message byte per item and returns the eight SHA-256 digest words, word 0 first,
// after the item that ends the message. A byte item is accepted as soon as it is offered, except the byte
// that completes a 64-byte block: the working variables load at the edge that takes it, and
// the input then stays not ready while the single round unit runs its 64 rounds at one per
// cycle, and then folds them into the chain value. Closing a message costs one padding step
// and one block, or two blocks when the 0x80 byte leaves no room for the 8-byte length in the
// last block, and then eight output items; the input is not ready until the last digest word
// has been taken. The block then restarts for the next message.
module sha256_stream_hasher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  shs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output shs_pkg::t_out_item o_out_item
);

    shs_pkg::t_state        r_state;
    shs_pkg::t_state        n_state;
    shs_pkg::t_state        r_ret;
    shs_pkg::t_state        n_ret;
    logic [shs_pkg::CountW-1:0] r_count;
    logic [2:0]             r_word;

    logic               in_acc;
    logic               out_acc;
    logic [5:0]         pos;
    logic               blk_full;
    logic               last_out;
    shs_pkg::t_core_cmd cmd;
    logic               core_done;
    shs_pkg::t_word     digest;

    assign pos      = r_count[5:0];
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = o_out_valid && i_out_ready;
    assign blk_full = in_acc && i_in_item.has_byte && (pos == shs_pkg::LastPos);
    assign last_out = out_acc && (r_word == shs_pkg::LastIdx);

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            shs_pkg::ST_IDLE: begin
                if (blk_full) begin
                    n_state = shs_pkg::ST_WAIT;
                    n_ret   = i_in_item.end_of_message ? shs_pkg::ST_PAD : shs_pkg::ST_IDLE;
                end else if (in_acc && i_in_item.end_of_message) begin
                    n_state = shs_pkg::ST_PAD;
                end
            end
            shs_pkg::ST_PAD: begin
                n_state = shs_pkg::ST_WAIT;
                // no room left for the length: it goes into an extra block
                n_ret   = (pos >= shs_pkg::LenPos) ? shs_pkg::ST_LEN : shs_pkg::ST_OUT;
            end
            shs_pkg::ST_LEN: begin
                n_state = shs_pkg::ST_WAIT;
                n_ret   = shs_pkg::ST_OUT;
            end
            shs_pkg::ST_WAIT: begin
                if (core_done) n_state = r_ret;
            end
            shs_pkg::ST_OUT: begin
                if (last_out) n_state = shs_pkg::ST_IDLE;
            end
            default: begin
                n_state = shs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and core commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        cmd         = '0;
        cmd.idx     = pos[5:2];
        cmd.lane    = pos[1:0];
        cmd.data    = i_in_item.msg_byte;
        cmd.bit_len = {r_count, 3'b000};
        cmd.init    = last_out;
        case (r_state)
            shs_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                cmd.wr_byte = in_acc && i_in_item.has_byte;
                cmd.start   = blk_full;
            end
            shs_pkg::ST_PAD: begin
                cmd.wr_pad = 1'b1;
                cmd.wr_len = (pos < shs_pkg::LenPos);
                cmd.start  = 1'b1;
            end
            shs_pkg::ST_LEN: begin
                cmd.clr    = 1'b1;
                cmd.wr_len = 1'b1;
                cmd.start  = 1'b1;
            end
            shs_pkg::ST_WAIT: begin
                o_in_ready = 1'b0;
            end
            shs_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shs_pkg::ST_IDLE;
            r_ret   <= shs_pkg::ST_IDLE;
            r_count <= '0;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (last_out)
                r_count <= '0;
            else if (in_acc && i_in_item.has_byte)
                r_count <= r_count + shs_pkg::CountW'(1);
            if (out_acc) r_word <= r_word + 3'd1;
        end
    end

    shs_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_word_sel    (r_word),
        .o_done        (core_done),
        .o_digest_word (digest)
    );

    assign o_out_item.digest_word = digest;
    assign o_out_item.word_index  = r_word;
    assign o_out_item.last_word   = (r_word == shs_pkg::LastIdx);

endmodule
